FILE: hdl/akd_pkg.sv
package akd_pkg;

   // key classes of one sample
   localparam logic [2:0] CLS_IDLE      = 3'd0;
   localparam logic [2:0] CLS_SET       = 3'd1;
   localparam logic [2:0] CLS_MODE      = 3'd2;
   localparam logic [2:0] CLS_VOL_MINUS = 3'd3;
   localparam logic [2:0] CLS_VOL_PLUS  = 3'd4;
   localparam logic [2:0] CLS_UNKNOWN   = 3'd5;

   // register indexes of the csr port
   localparam logic [2:0] REG_IDLE_LOW   = 3'd0;
   localparam logic [2:0] REG_IDLE_HIGH  = 3'd1;
   localparam logic [2:0] REG_SET_UPPER  = 3'd2;
   localparam logic [2:0] REG_MODE_UPPER = 3'd3;
   localparam logic [2:0] REG_VMIN_UPPER = 3'd4;
   localparam logic [2:0] REG_VPLS_UPPER = 3'd5;
   localparam logic [2:0] REG_DEBOUNCE   = 3'd6;
   localparam logic [2:0] REG_LONG_TICKS = 3'd7;

   localparam int SAMPLE_WIDTH = 12;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] idle_low_limit;
      logic [SAMPLE_WIDTH-1:0] idle_high_limit;
      logic [SAMPLE_WIDTH-1:0] set_upper;
      logic [SAMPLE_WIDTH-1:0] mode_upper;
      logic [SAMPLE_WIDTH-1:0] vol_minus_upper;
      logic [SAMPLE_WIDTH-1:0] vol_plus_upper;
   } thresh_type;

endpackage

FILE: hdl/akd_classify.sv
module akd_classify (
   input  akd_pkg::thresh_type                 thresh,
   input  logic [akd_pkg::SAMPLE_WIDTH-1:0]    sample,
   output logic [2:0]                          key_class
);

   // apply thresholds in fixed priority order; overlaps shadow later classes
   always_comb begin
      if (sample <= thresh.idle_low_limit || sample >= thresh.idle_high_limit) begin
         key_class = akd_pkg::CLS_IDLE;
      end else if (sample < thresh.set_upper) begin
         key_class = akd_pkg::CLS_SET;
      end else if (sample < thresh.mode_upper) begin
         key_class = akd_pkg::CLS_MODE;
      end else if (sample < thresh.vol_minus_upper) begin
         key_class = akd_pkg::CLS_VOL_MINUS;
      end else if (sample < thresh.vol_plus_upper) begin
         key_class = akd_pkg::CLS_VOL_PLUS;
      end else begin
         key_class = akd_pkg::CLS_UNKNOWN;
      end
   end

endmodule

FILE: hdl/adc_ladder_key_debouncer_top.sv
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+--------------------------------------------
// req      | in  | req_tvalid/req_tready | tdata: raw_sample[11:0]; tuser: read_ok
// rsp      | out | rsp_tvalid/rsp_tready | tdata: event_key[2:0]; tuser: long event flag
// csr      | in  | csr_valid/csr_ready   | csr_index[2:0], csr_data[15:0]
//
// One item per cycle unless the result stalls: an item waits in the input
// register, then the classifier, debounce counter and hold timer update in a
// single pass and at most one event lands in the result register. rsp_tvalid
// rises after the input register and then the result register. Synchronous
// active-high reset restores default thresholds, clears all key state. A stalled
// result holds the update stage; the input register still takes one more item.
module adc_ladder_key_debouncer_top #(
   parameter int REPEAT_COUNT_WIDTH = 8,
   parameter int HOLD_COUNT_WIDTH   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] raw_sample, [15:12] zero
   input  logic [0:0]  req_tuser,   // [0] read_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] event_key, [7:3] zero
   output logic [0:0]  rsp_tuser,   // [0] long event flag
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int RW = REPEAT_COUNT_WIDTH;
   localparam int HW = HOLD_COUNT_WIDTH;
   localparam int NRW = (RW > 8) ? RW : 8;
   localparam int NHW = (HW > 16) ? HW : 16;
   localparam logic [RW-1:0] REPEAT_MAX = {RW{1'b1}};
   localparam logic [HW-1:0] HOLD_MAX = {HW{1'b1}};

   // configuration registers
   akd_pkg::thresh_type thresh_ff;
   logic [7:0]          debounce_ff;
   logic [15:0]         long_ticks_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [11:0] in_sample_ff;
   logic        in_ok_ff;

   // key state
   logic [2:0]    stable_ff, stable_in;
   logic [2:0]    cand_ff, cand_in;
   logic [RW-1:0] repeat_ff, repeat_in;
   logic [HW-1:0] hold_ff, hold_in;
   logic          hold_active_ff, hold_active_in;
   logic          long_done_ff, long_done_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_key_ff, rsp_key_in;
   logic       rsp_long_ff, rsp_long_in;

   logic          advance;
   logic [2:0]    sample_class;
   logic [NRW-1:0] need_w;
   logic [RW-1:0] need;
   logic [NHW-1:0] hold_need_w;
   logic [HW-1:0] hold_need;
   logic          emit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.idle_low_limit  <= 12'd150;
         thresh_ff.idle_high_limit <= 12'd2300;
         thresh_ff.set_upper       <= 12'd600;
         thresh_ff.mode_upper      <= 12'd1150;
         thresh_ff.vol_minus_upper <= 12'd1600;
         thresh_ff.vol_plus_upper  <= 12'd2300;
         debounce_ff               <= 8'd3;
         long_ticks_ff             <= 16'd50;
      end else if (csr_valid) begin
         case (csr_index)
            akd_pkg::REG_IDLE_LOW:   thresh_ff.idle_low_limit  <= csr_data[11:0];
            akd_pkg::REG_IDLE_HIGH:  thresh_ff.idle_high_limit <= csr_data[11:0];
            akd_pkg::REG_SET_UPPER:  thresh_ff.set_upper       <= csr_data[11:0];
            akd_pkg::REG_MODE_UPPER: thresh_ff.mode_upper      <= csr_data[11:0];
            akd_pkg::REG_VMIN_UPPER: thresh_ff.vol_minus_upper <= csr_data[11:0];
            akd_pkg::REG_VPLS_UPPER: thresh_ff.vol_plus_upper  <= csr_data[11:0];
            akd_pkg::REG_DEBOUNCE:   debounce_ff               <= csr_data[7:0];
            akd_pkg::REG_LONG_TICKS: long_ticks_ff             <= csr_data;
            default: ;
         endcase
      end
   end

   // the update stage moves whenever the result register is free or draining
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_sample_ff <= req_tdata[11:0];
         in_ok_ff     <= req_tuser[0];
      end
   end

   akd_classify u_classify (
      .thresh    (thresh_ff),
      .sample    (in_sample_ff),
      .key_class (sample_class)
   );

   // debounce target: zero acts as one; clip it and the hold target to the counters
   always_comb begin
      need_w = NRW'(debounce_ff);
      if (need_w == '0) begin
         need_w = NRW'(1);
      end
      if (need_w > NRW'(REPEAT_MAX)) begin
         need_w = NRW'(REPEAT_MAX);
      end
      need = need_w[RW-1:0];

      hold_need_w = NHW'(long_ticks_ff);
      if (hold_need_w > NHW'(HOLD_MAX)) begin
         hold_need_w = NHW'(HOLD_MAX);
      end
      hold_need = hold_need_w[HW-1:0];
   end

   always_comb begin
      stable_in      = stable_ff;
      cand_in        = cand_ff;
      repeat_in      = repeat_ff;
      hold_in        = hold_ff;
      hold_active_in = hold_active_ff;
      long_done_in   = long_done_ff;
      emit           = 1'b0;
      rsp_key_in     = rsp_key_ff;
      rsp_long_in    = rsp_long_ff;

      if (in_valid_ff && advance) begin
         // the hold timer ticks even on a failed read
         if (hold_active_ff && hold_ff != HOLD_MAX) begin
            hold_in = hold_ff + HW'(1);
         end

         if (in_ok_ff) begin
            if (sample_class != cand_ff) begin
               cand_in   = sample_class;
               repeat_in = RW'(1);
            end else if (repeat_ff < need) begin
               repeat_in = repeat_ff + RW'(1);
            end

            if (repeat_in >= need && cand_in != stable_ff) begin
               stable_in = cand_in;
               if (stable_ff == akd_pkg::CLS_IDLE && cand_in != akd_pkg::CLS_UNKNOWN) begin
                  // press start
                  hold_in        = '0;
                  hold_active_in = 1'b1;
                  long_done_in   = 1'b0;
               end else if (stable_ff != akd_pkg::CLS_IDLE &&
                            cand_in == akd_pkg::CLS_IDLE) begin
                  // release: short press unless long already went out or the key is unknown
                  emit           = !long_done_ff && stable_ff != akd_pkg::CLS_UNKNOWN;
                  rsp_key_in     = stable_ff;
                  rsp_long_in    = 1'b0;
                  hold_in        = '0;
                  hold_active_in = 1'b0;
                  long_done_in   = 1'b0;
               end
            end

            if (!emit && stable_in != akd_pkg::CLS_IDLE &&
                stable_in != akd_pkg::CLS_UNKNOWN && !long_done_in &&
                hold_active_in && hold_in >= hold_need) begin
               emit         = 1'b1;
               long_done_in = 1'b1;
               rsp_key_in   = stable_in;
               rsp_long_in  = 1'b1;
            end
         end
      end

      rsp_valid_in = advance ? (in_valid_ff && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         stable_ff      <= akd_pkg::CLS_IDLE;
         cand_ff        <= akd_pkg::CLS_IDLE;
         repeat_ff      <= '0;
         hold_ff        <= '0;
         hold_active_ff <= 1'b0;
         long_done_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         stable_ff      <= stable_in;
         cand_ff        <= cand_in;
         repeat_ff      <= repeat_in;
         hold_ff        <= hold_in;
         hold_active_ff <= hold_active_in;
         long_done_ff   <= long_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // load the result payload only when a new event is written
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_key_ff  <= rsp_key_in;
         rsp_long_ff <= rsp_long_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {5'd0, rsp_key_ff};
   assign rsp_tuser[0] = rsp_long_ff;

   // events name a known key only
   a_event_key_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_key_ff >= akd_pkg::CLS_SET && rsp_key_ff <= akd_pkg::CLS_VOL_PLUS))
      else $error("event with unknown key");

   // a sent long press implies a timed press
   a_long_implies_timing: assert property (@(posedge clock) disable iff (reset)
      long_done_ff |-> hold_active_ff)
      else $error("long press flag without hold timing");

   // timing runs only while a key is stable
   a_timing_not_idle: assert property (@(posedge clock) disable iff (reset)
      hold_active_ff |-> stable_ff != akd_pkg::CLS_IDLE)
      else $error("hold timing while idle");

   // stopped timer sits at zero
   a_hold_cleared: assert property (@(posedge clock) disable iff (reset)
      !hold_active_ff |-> hold_ff == '0)
      else $error("hold count left over after release");

endmodule
